/* hdl/sorted_key_count_table_unit_assert.svh */
// Assertion macros shared by the sorted key count table unit.
`ifndef SORTED_KEY_COUNT_TABLE_UNIT_ASSERT_SVH
`define SORTED_KEY_COUNT_TABLE_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

`define SKCT_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

`define SKCT_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define SKCT_ASSERT_IMP(name, clk, rst_n, ante, cons)

`define SKCT_ASSERT_NEXT(name, clk, rst_n, ante, cons)

`endif

`endif

/* hdl/skct_pkg.sv */
// Package with types, codes and constants of the sorted key count table unit.
package skct_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int KEY_W        = 16;
    localparam int COUNT_W      = 16;
    localparam int USED_OUT_W   = 5;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    typedef struct packed {
        logic             operation;
        logic [KEY_W-1:0] key;
    } req_t;

    typedef struct packed {
        logic                  done_res;
        logic [COUNT_W-1:0]    key_count;
        logic [USED_OUT_W-1:0] entries_used;
    } rsp_t;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [COUNT_W-1:0] count;
    } entry_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEARCH_RD,
        ST_SEARCH_CMP,
        ST_DECIDE,
        ST_SHUP_RD,
        ST_SHUP_WR,
        ST_SHDN_RD,
        ST_SHDN_WR,
        ST_FINISH
    } state_t;

    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_ZERO,
        IDX_INC,
        IDX_DEC,
        IDX_USED
    } idx_op_t;

    typedef enum logic [1:0] {
        RD_IDX,
        RD_PREV,
        RD_NEXT
    } rd_sel_t;

    typedef enum logic [1:0] {
        WR_SHIFT,
        WR_INC,
        WR_DEC,
        WR_NEW
    } wr_sel_t;

    typedef enum logic [1:0] {
        USED_HOLD,
        USED_INC,
        USED_DEC
    } used_op_t;

    typedef enum logic [2:0] {
        RES_FULL,
        RES_MISS,
        RES_INC,
        RES_DEC,
        RES_NEW,
        RES_DEL
    } res_kind_t;

    typedef struct packed {
        logic      load_item;
        logic      rd_en;
        rd_sel_t   rd_sel;
        logic      wr_en;
        wr_sel_t   wr_sel;
        idx_op_t   idx_op;
        logic      capture_hit;
        logic      set_miss;
        used_op_t  used_op;
        logic      set_kind;
        res_kind_t kind;
        logic      load_result;
    } cmd_t;

    typedef struct packed {
        logic idx_is_used;
        logic idx_is_pos;
        logic next_is_used;
        logic key_le;
        logic full;
        logic present;
        logic hit_gt1;
        logic op_remove;
        logic res_free;
    } status_t;

endpackage

/* hdl/skct_ctrl.sv */
// Controller state machine that sequences search, shift and result transfer.
module skct_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  skct_pkg::status_t status,
    output skct_pkg::cmd_t    cmd
);
    import skct_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        req_ready       = 1'b0;
        cmd             = '0;
        cmd.rd_sel      = RD_IDX;
        cmd.wr_sel      = WR_SHIFT;
        cmd.idx_op      = IDX_HOLD;
        cmd.used_op     = USED_HOLD;
        cmd.kind        = RES_MISS;
        case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load_item = 1'b1;
                    cmd.idx_op    = IDX_ZERO;
                    state_next    = ST_SEARCH_RD;
                end
            end
            ST_SEARCH_RD:
            begin
                if (status.idx_is_used)
                begin
                    cmd.set_miss = 1'b1;
                    state_next   = ST_DECIDE;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_IDX;
                    state_next = ST_SEARCH_CMP;
                end
            end
            ST_SEARCH_CMP:
            begin
                if (status.key_le)
                begin
                    cmd.capture_hit = 1'b1;
                    state_next      = ST_DECIDE;
                end
                else
                begin
                    cmd.idx_op = IDX_INC;
                    state_next = ST_SEARCH_RD;
                end
            end
            ST_DECIDE:
            begin
                if (!status.op_remove)
                begin
                    if (status.full)
                    begin
                        cmd.set_kind = 1'b1;
                        cmd.kind     = RES_FULL;
                        state_next   = ST_FINISH;
                    end
                    else if (status.present)
                    begin
                        cmd.wr_en    = 1'b1;
                        cmd.wr_sel   = WR_INC;
                        cmd.set_kind = 1'b1;
                        cmd.kind     = RES_INC;
                        state_next   = ST_FINISH;
                    end
                    else
                    begin
                        cmd.idx_op = IDX_USED;
                        state_next = ST_SHUP_RD;
                    end
                end
                else
                begin
                    if (!status.present)
                    begin
                        cmd.set_kind = 1'b1;
                        cmd.kind     = RES_MISS;
                        state_next   = ST_FINISH;
                    end
                    else if (status.hit_gt1)
                    begin
                        cmd.wr_en    = 1'b1;
                        cmd.wr_sel   = WR_DEC;
                        cmd.set_kind = 1'b1;
                        cmd.kind     = RES_DEC;
                        state_next   = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_SHDN_RD;
                    end
                end
            end
            ST_SHUP_RD:
            begin
                if (status.idx_is_pos)
                begin
                    cmd.wr_en    = 1'b1;
                    cmd.wr_sel   = WR_NEW;
                    cmd.used_op  = USED_INC;
                    cmd.set_kind = 1'b1;
                    cmd.kind     = RES_NEW;
                    state_next   = ST_FINISH;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_PREV;
                    state_next = ST_SHUP_WR;
                end
            end
            ST_SHUP_WR:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = WR_SHIFT;
                cmd.idx_op = IDX_DEC;
                state_next = ST_SHUP_RD;
            end
            ST_SHDN_RD:
            begin
                if (status.next_is_used)
                begin
                    cmd.used_op  = USED_DEC;
                    cmd.set_kind = 1'b1;
                    cmd.kind     = RES_DEL;
                    state_next   = ST_FINISH;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_NEXT;
                    state_next = ST_SHDN_WR;
                end
            end
            ST_SHDN_WR:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = WR_SHIFT;
                cmd.idx_op = IDX_INC;
                state_next = ST_SHDN_RD;
            end
            ST_FINISH:
            begin
                if (status.res_free)
                begin
                    cmd.load_result = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* hdl/skct_dpath.sv */
// Datapath with the entry memory, search pointer, fill count and result register.
`include "sorted_key_count_table_unit_assert.svh"

module skct_dpath #(
    parameter int CAPACITY = skct_pkg::CAPACITY_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  skct_pkg::req_t    req,
    input  skct_pkg::cmd_t    cmd,
    input  logic              rsp_ready,
    output skct_pkg::status_t status,
    output logic              rsp_valid,
    output skct_pkg::rsp_t    rsp
);
    import skct_pkg::*;

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    entry_t mem [CAPACITY];

    logic [CNT_W-1:0]   idx_reg;
    logic [CNT_W-1:0]   idx_next;
    logic [CNT_W-1:0]   used_reg;
    logic [CNT_W-1:0]   used_next;
    logic               res_valid_reg;
    logic [CNT_W-1:0]   pos_reg;
    logic [KEY_W-1:0]   key_reg;
    logic               op_reg;
    logic [COUNT_W-1:0] hit_count_reg;
    logic               present_reg;
    res_kind_t          kind_reg;
    entry_t             rd_data_reg;
    rsp_t               rsp_reg;

    logic [CNT_W-1:0]   idx_inc;
    logic [CNT_W-1:0]   idx_dec;
    logic [CNT_W-1:0]   rd_ptr;
    logic [CNT_W-1:0]   wr_ptr;
    logic [IDX_W-1:0]   rd_addr;
    logic [IDX_W-1:0]   wr_addr;
    entry_t             wr_data;
    logic [COUNT_W-1:0] inc_count;
    logic [COUNT_W-1:0] dec_count;
    logic [31:0]        used_wide;
    rsp_t               rsp_next;

    assign idx_inc   = idx_reg + 1'b1;
    assign idx_dec   = idx_reg - 1'b1;
    assign inc_count = (hit_count_reg == COUNT_MAX) ? hit_count_reg : hit_count_reg + 1'b1;
    assign dec_count = hit_count_reg - 1'b1;
    assign used_wide = 32'(used_reg);

    always_comb
    begin
        case (cmd.rd_sel)
            RD_PREV: rd_ptr = idx_dec;
            RD_NEXT: rd_ptr = idx_inc;
            default: rd_ptr = idx_reg;
        endcase
    end

    always_comb
    begin
        wr_ptr       = pos_reg;
        wr_data.key  = key_reg;
        wr_data.count = inc_count;
        case (cmd.wr_sel)
            WR_SHIFT:
            begin
                wr_ptr  = idx_reg;
                wr_data = rd_data_reg;
            end
            WR_INC:
            begin
                wr_data.count = inc_count;
            end
            WR_DEC:
            begin
                wr_data.count = dec_count;
            end
            WR_NEW:
            begin
                wr_data.count = COUNT_W'(1);
            end
            default:
            begin
                wr_data.count = inc_count;
            end
        endcase
    end

    assign rd_addr = rd_ptr[IDX_W-1:0];
    assign wr_addr = wr_ptr[IDX_W-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        case (cmd.idx_op)
            IDX_ZERO: idx_next = '0;
            IDX_INC:  idx_next = idx_inc;
            IDX_DEC:  idx_next = idx_dec;
            IDX_USED: idx_next = used_reg;
            default:  idx_next = idx_reg;
        endcase
    end

    always_comb
    begin
        case (cmd.used_op)
            USED_INC: used_next = used_reg + 1'b1;
            USED_DEC: used_next = used_reg - 1'b1;
            default:  used_next = used_reg;
        endcase
    end

    always_comb
    begin
        rsp_next.entries_used = used_wide[USED_OUT_W-1:0];
        rsp_next.done_res     = 1'b1;
        rsp_next.key_count    = '0;
        case (kind_reg)
            RES_FULL:
            begin
                rsp_next.done_res  = 1'b0;
                rsp_next.key_count = present_reg ? hit_count_reg : '0;
            end
            RES_MISS:
            begin
                rsp_next.done_res = 1'b0;
            end
            RES_INC:
            begin
                rsp_next.key_count = inc_count;
            end
            RES_DEC:
            begin
                rsp_next.key_count = dec_count;
            end
            RES_NEW:
            begin
                rsp_next.key_count = COUNT_W'(1);
            end
            RES_DEL:
            begin
                rsp_next.key_count = '0;
            end
            default:
            begin
                rsp_next.done_res = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            used_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg  <= idx_next;
            used_reg <= used_next;
            if (cmd.load_result)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            key_reg <= req.key;
            op_reg  <= req.operation;
        end
        if (cmd.capture_hit)
        begin
            pos_reg       <= idx_reg;
            present_reg   <= (key_reg == rd_data_reg.key);
            hit_count_reg <= rd_data_reg.count;
        end
        else if (cmd.set_miss)
        begin
            pos_reg     <= idx_reg;
            present_reg <= 1'b0;
        end
        if (cmd.set_kind)
        begin
            kind_reg <= cmd.kind;
        end
        if (cmd.load_result)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign status.idx_is_used  = (idx_reg == used_reg);
    assign status.idx_is_pos   = (idx_reg == pos_reg);
    assign status.next_is_used = (idx_inc == used_reg);
    assign status.key_le       = (key_reg <= rd_data_reg.key);
    assign status.full         = (used_reg == CNT_W'(CAPACITY));
    assign status.present      = present_reg;
    assign status.hit_gt1      = (hit_count_reg > COUNT_W'(1));
    assign status.op_remove    = (op_reg == OP_REMOVE);
    assign status.res_free     = !res_valid_reg || rsp_ready;

    assign rsp_valid = res_valid_reg;
    assign rsp       = rsp_reg;

    `SKCT_ASSERT_IMP(a_used_in_range, clk, rst_n, 1'b1, used_reg <= CNT_W'(CAPACITY))
    `SKCT_ASSERT_IMP(a_no_grow_full, clk, rst_n, cmd.used_op == USED_INC, !status.full)
    `SKCT_ASSERT_IMP(a_no_shrink_empty, clk, rst_n, cmd.used_op == USED_DEC, used_reg != '0)
    `SKCT_ASSERT_IMP(a_result_not_lost, clk, rst_n, cmd.load_result, !res_valid_reg || rsp_ready)
    `SKCT_ASSERT_NEXT(a_hit_in_used, clk, rst_n, cmd.capture_hit, pos_reg < used_reg)

endmodule

/* hdl/sorted_key_count_table_unit.sv */
// Top level of the sorted key count table unit.
// The unit keeps up to CAPACITY distinct 16-bit keys in ascending order, each with
// a saturating 16-bit count. A request transfer on req (req_valid, req_ready) carries
// an operation, insert or remove, and a key. Every request yields exactly one
// response transfer on rsp (rsp_valid, rsp_ready) with the done flag, the key's count
// after the operation and the number of distinct keys held.
// The entries live in a memory with one write and one registered read port. The
// search walks the entries from the bottom, reading and then comparing each entry, and
// an insert of a new key or the delete of a last copy moves the entries above it, each
// with a read and then a write. For such an insert or delete, the search and the shift
// together visit each entry held.
// Requests are taken one at a time; req_ready is high only while no request is open,
// and the next request can be taken in the cycle after the response register is loaded.
// The response waits in an output register, so the next request is taken while the
// receiver stalls; a finished request whose response register is still full waits.
// Reset empties the table at once; entries are never read beyond the fill count.
module sorted_key_count_table_unit #(
    parameter int CAPACITY = skct_pkg::CAPACITY_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  skct_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output skct_pkg::rsp_t rsp
);
    import skct_pkg::*;

    cmd_t    cmd;
    status_t status;

    skct_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .status    (status),
        .cmd       (cmd)
    );

    skct_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .rsp_ready (rsp_ready),
        .status    (status),
        .rsp_valid (rsp_valid),
        .rsp       (rsp)
    );

endmodule

/* test/tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the sorted key count table unit.
module tb;
    import skct_pkg::*;

    localparam int TABLE_DEPTH = CAPACITY_DEF;
    localparam int CYCLE_LIMIT = 500_000;
    localparam int POOL_SIZE   = 20;

    class table_scoreboard;
        logic [KEY_W-1:0]   keys [TABLE_DEPTH];
        logic [COUNT_W-1:0] counts [TABLE_DEPTH];
        int unsigned        used;
        rsp_t               expected_q [$];
        int unsigned        errors;

        function new();
            used = 0;
            errors = 0;
        endfunction

        function void note_request(req_t r);
            int unsigned pos;
            int          i;
            bit          present;
            rsp_t        want;
            pos = 0;
            while (pos < used && r.key > keys[pos])
                pos++;
            present = (pos < used) && (keys[pos] == r.key);
            want.done_res = 1'b0;
            want.key_count = '0;
            if (r.operation == OP_INSERT)
            begin
                if (used >= TABLE_DEPTH)
                begin
                    if (present)
                        want.key_count = counts[pos];
                end
                else if (present)
                begin
                    if (counts[pos] != COUNT_MAX)
                        counts[pos]++;
                    want.key_count = counts[pos];
                    want.done_res = 1'b1;
                end
                else
                begin
                    for (i = used; i > int'(pos); i--)
                    begin
                        keys[i] = keys[i-1];
                        counts[i] = counts[i-1];
                    end
                    keys[pos] = r.key;
                    counts[pos] = 1;
                    used++;
                    want.key_count = 1;
                    want.done_res = 1'b1;
                end
            end
            else if (present)
            begin
                want.done_res = 1'b1;
                if (counts[pos] > 1)
                begin
                    counts[pos]--;
                    want.key_count = counts[pos];
                end
                else
                begin
                    for (i = pos; i + 1 < int'(used); i++)
                    begin
                        keys[i] = keys[i+1];
                        counts[i] = counts[i+1];
                    end
                    used--;
                end
            end
            want.entries_used = USED_OUT_W'(used);
            expected_q.insert(expected_q.size(), want);
        endfunction

        task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
            errors++;
            $display("Mismatch in %s: got %0d, expected %0d at %0t", what, got, want, $time);
        endtask

        task check_response(rsp_t got);
            rsp_t want;
            if (expected_q.size() == 0)
            begin
                report_mismatch("response with nothing outstanding", 32'(got.key_count), 0);
                return;
            end
            want = expected_q.pop_front();
            if (got.done_res !== want.done_res)
                report_mismatch("done_res", 32'(got.done_res), 32'(want.done_res));
            if (got.key_count !== want.key_count)
                report_mismatch("key_count", 32'(got.key_count), 32'(want.key_count));
            if (got.entries_used !== want.entries_used)
                report_mismatch("entries_used", 32'(got.entries_used),
                                32'(want.entries_used));
        endtask
    endclass

    logic clk;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    req_t req = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_t rsp;

    bit tx_idle = 1'b1;
    bit rx_idle = 1'b1;
    int stall_left = 0;
    int cycle_count = 0;

    table_scoreboard sb = new;

    sorted_key_count_table_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
            sb.check_response(rsp);
        if (stall_left > 0)
            stall_left--;
        else if (rx_idle && $urandom_range(0, 5) == 0)
            stall_left = $urandom_range(1, 18);
        rsp_ready <= (stall_left == 0);
    end

    task automatic send(input logic op, input logic [KEY_W-1:0] key);
        req_t item;
        int   gap;
        item.operation = op;
        item.key = key;
        if (tx_idle && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 18);
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= item;
        do
            @(posedge clk);
        while (!req_ready);
        sb.note_request(item);
    endtask

    task automatic run_directed();
        int i;
        send(OP_REMOVE, 16'h0000);
        send(OP_INSERT, 16'h8000);
        send(OP_INSERT, 16'h0000);
        send(OP_INSERT, 16'hFFFF);
        send(OP_INSERT, 16'h8000);
        send(OP_REMOVE, 16'h1234);
        send(OP_REMOVE, 16'h8000);
        send(OP_REMOVE, 16'h8000);
        send(OP_REMOVE, 16'hFFFF);
        send(OP_REMOVE, 16'h0000);
        for (i = TABLE_DEPTH - 1; i >= 0; i--)
            send(OP_INSERT, KEY_W'(i * 16'h1111));
        send(OP_INSERT, 16'h7777);
        send(OP_INSERT, 16'h7778);
        send(OP_REMOVE, 16'h7777);
    endtask

    task automatic run_random(input int n_items);
        logic [KEY_W-1:0] pool [POOL_SIZE];
        logic [KEY_W-1:0] key;
        logic             op;
        int               sent;
        int               seg_len;
        int               insert_pct;
        int               i;
        pool[0] = '0;
        pool[1] = '1;
        for (i = 2; i < POOL_SIZE; i++)
            pool[i] = (i % 4 == 3) ? pool[i-1] + 1'b1 : KEY_W'($urandom_range(0, 65535));
        sent = 0;
        while (sent < n_items)
        begin
            seg_len = $urandom_range(40, 120);
            case ($urandom_range(0, 2))
                0: insert_pct = 85;
                1: insert_pct = 50;
                default: insert_pct = 15;
            endcase
            tx_idle = ($urandom_range(0, 3) != 0);
            rx_idle = ($urandom_range(0, 3) != 0);
            repeat (seg_len)
            begin
                op = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_REMOVE;
                if ($urandom_range(0, 9) == 0)
                    key = KEY_W'($urandom_range(0, 65535));
                else if (op == OP_REMOVE && sb.used != 0 && $urandom_range(0, 1) == 1)
                    key = sb.keys[$urandom_range(0, sb.used - 1)];
                else
                    key = pool[$urandom_range(0, POOL_SIZE - 1)];
                send(op, key);
                sent++;
            end
        end
    endtask

    task automatic run_capacity();
        logic [KEY_W-1:0] hot_key;
        int               i;
        hot_key = KEY_W'($urandom_range(0, 65535));
        repeat (8)
            send(OP_INSERT, hot_key);
        send(OP_REMOVE, hot_key);
        send(OP_INSERT, hot_key);
        for (i = 1; i < TABLE_DEPTH; i++)
            send(OP_INSERT, hot_key ^ KEY_W'(i << 12));
        send(OP_INSERT, hot_key);
        send(OP_INSERT, ~hot_key);
        send(OP_REMOVE, hot_key);
        send(OP_REMOVE, hot_key ^ 16'h1000);
    endtask

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("sorted_key_count_table_unit test failed");
        $finish;
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        run_random(1200);
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        run_capacity();
        req_valid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (4 * TABLE_DEPTH + 10) @(posedge clk);
        if (sb.errors == 0)
            $display("sorted_key_count_table_unit test passed");
        else
            $display("sorted_key_count_table_unit test failed");
        $finish;
    end
endmodule

/* filelist.f */
+incdir+hdl
hdl/skct_pkg.sv
hdl/skct_ctrl.sv
hdl/skct_dpath.sv
hdl/sorted_key_count_table_unit.sv
test/tb.sv
